FILE: src/rlpm_pkg.sv
package rlpm_pkg;

    // Field widths (fixed by the item format)
    localparam int IDX_W  = 5;
    localparam int ADDR_W = 32;

    // Stream kind codes carried on s_tuser
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Input tdata layout, lowest bit first
    localparam int IN_IDX_LO   = 0;
    localparam int IN_DEST_LO  = IN_IDX_LO + IDX_W;
    localparam int IN_MASK_LO  = IN_DEST_LO + ADDR_W;
    localparam int IN_VALID_LO = IN_MASK_LO + ADDR_W;
    localparam int IN_ADDR_LO  = IN_VALID_LO + 1;
    localparam int IN_BITS     = IN_ADDR_LO + ADDR_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout, lowest bit first
    localparam int OUT_FOUND_LO = 0;
    localparam int OUT_IDX_LO   = OUT_FOUND_LO + 1;
    localparam int OUT_MASK_LO  = OUT_IDX_LO + IDX_W;
    localparam int OUT_BITS     = OUT_MASK_LO + ADDR_W;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // Running best match of a scan
    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] mask;
    } rlpm_best_t;

endpackage

FILE: src/rlpm_ram.sv
module rlpm_ram
    #(
        parameter int WIDTH = 64,
        parameter int DEPTH = 32,
        localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic             clk,
        input  logic             wr_en,
        input  logic [AW-1:0]    wr_addr,
        input  logic [WIDTH-1:0] wr_data,
        input  logic             rd_en,
        input  logic [AW-1:0]    rd_addr,
        output logic [WIDTH-1:0] rd_data
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/rlpm_cmp.sv
module rlpm_cmp
    import rlpm_pkg::*;
    (
        input  logic [ADDR_W-1:0] addr,
        input  logic [ADDR_W-1:0] dest,
        input  logic [ADDR_W-1:0] mask,
        input  logic              slot_valid,
        input  logic [IDX_W-1:0]  slot_idx,
        input  rlpm_best_t        best_in,
        output rlpm_best_t        best_out
    );

    logic match;
    logic take;

    // prefix match, then strictly greater mask (earlier slot keeps a tie)
    assign match = ((addr ^ dest) & mask) == '0;
    assign take  = slot_valid && match && (!best_in.hit || (mask > best_in.mask));

    always_comb
    begin
        best_out = best_in;
        if (take)
        begin
            best_out.hit  = 1'b1;
            best_out.idx  = slot_idx;
            best_out.mask = mask;
        end
    end

endmodule

FILE: src/route_longest_prefix_match_top.sv
// Channel  | Dir | Handshake         | Payload
// ---------+-----+-------------------+-------------------------------------------
// s_*      | in  | s_tvalid/s_tready | tuser kind, tdata entry or lookup address
// m_*      | out | m_tvalid/m_tready | tdata found, match_index, match_mask
//
// A write transfer writes its slot at the accepting edge.
// A lookup is accepted in IDLE; in SCAN one compare unit then walks the route
// RAM one slot per cycle, DRAIN covers the read latency and DONE loads the
// output register. SLOTS is min(TABLE_DEPTH, 32), as entry_index reaches 31.
// Reset clears the valid bits and control only; no clearing pass is needed.
// s_tready is high only while idle. The result sits in an output register, so
// a new transfer is taken while m_tready holds the previous result back; a
// finished lookup waits in DONE if the output register is still full.
module route_longest_prefix_match_top
    import rlpm_pkg::*;
    #(
        parameter int TABLE_DEPTH = 32
    )
    (
        input  logic                   clk,
        input  logic                   rst_n,
        input  logic                   s_tvalid,
        output logic                   s_tready,
        // [4:0] entry_index, [36:5] entry_dest, [68:37] entry_mask,
        // [69] entry_valid, [101:70] lookup_address, [103:102] zero
        input  logic [IN_TDATA_W-1:0]  s_tdata,
        // [0] kind
        input  logic                   s_tuser,
        output logic                   m_tvalid,
        input  logic                   m_tready,
        // [0] found, [5:1] match_index, [37:6] match_mask, [39:38] zero
        output logic [OUT_TDATA_W-1:0] m_tdata
    );

    // Only slots below 32 can ever be written
    localparam int SLOTS = (TABLE_DEPTH < 32) ? TABLE_DEPTH : 32;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W:0] SLOTS_LIM = (IDX_W + 1)'(SLOTS);
    localparam logic [AW-1:0]  LAST_SLOT = AW'(SLOTS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     rd_cnt_reg, rd_cnt_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    rlpm_best_t        best_reg, best_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic              out_vld_reg, out_vld_next;
    rlpm_best_t        out_reg, out_next;

    // input field split
    logic [IDX_W-1:0]  in_idx;
    logic [ADDR_W-1:0] in_dest;
    logic [ADDR_W-1:0] in_mask;
    logic              in_valid;
    logic [ADDR_W-1:0] in_addr;

    assign in_idx   = s_tdata[IN_IDX_LO +: IDX_W];
    assign in_dest  = s_tdata[IN_DEST_LO +: ADDR_W];
    assign in_mask  = s_tdata[IN_MASK_LO +: ADDR_W];
    assign in_valid = s_tdata[IN_VALID_LO];
    assign in_addr  = s_tdata[IN_ADDR_LO +: ADDR_W];

    logic in_xfer;
    logic wr_hit;
    logic rd_en;
    logic [2*ADDR_W-1:0] rd_data;
    rlpm_best_t          cmp_best;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign wr_hit   = in_xfer && (s_tuser == KIND_WRITE) && ({1'b0, in_idx} < SLOTS_LIM);
    assign rd_en    = (state_reg == ST_SCAN);

    // route RAM, {mask, dest} per slot
    rlpm_ram
        #(
            .WIDTH (2 * ADDR_W),
            .DEPTH (SLOTS)
        )
        u_ram
        (
            .clk     (clk),
            .wr_en   (wr_hit),
            .wr_addr (AW'(in_idx)),
            .wr_data ({in_mask, in_dest}),
            .rd_en   (rd_en),
            .rd_addr (rd_cnt_reg),
            .rd_data (rd_data)
        );

    // shared compare unit, one slot per cycle
    rlpm_cmp u_cmp
        (
            .addr       (addr_reg),
            .dest       (rd_data[ADDR_W-1:0]),
            .mask       (rd_data[2*ADDR_W-1:ADDR_W]),
            .slot_valid (valid_reg[cmp_idx_reg]),
            .slot_idx   (IDX_W'(cmp_idx_reg)),
            .best_in    (best_reg),
            .best_out   (cmp_best)
        );

    always_comb
    begin
        state_next   = state_reg;
        rd_cnt_next  = rd_cnt_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = rd_cnt_reg;
        addr_next    = addr_reg;
        best_next    = best_reg;
        valid_next   = valid_reg;
        out_vld_next = out_vld_reg;
        out_next     = out_reg;

        if (out_vld_reg && m_tready)
        begin
            out_vld_next = 1'b0;
        end

        if (wr_hit)
        begin
            valid_next[AW'(in_idx)] = in_valid;
        end

        if (cmp_vld_reg)
        begin
            best_next = cmp_best;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (s_tuser == KIND_LOOKUP))
                begin
                    addr_next   = in_addr;
                    best_next   = '0;
                    rd_cnt_next = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmp_vld_next = 1'b1;
                if (rd_cnt_reg == LAST_SLOT)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next = 1'b1;
                    out_next     = best_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cmp_vld_reg <= 1'b0;
            valid_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            valid_reg   <= valid_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        rd_cnt_reg  <= rd_cnt_next;
        cmp_idx_reg <= cmp_idx_next;
        addr_reg    <= addr_next;
        best_reg    <= best_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {(OUT_TDATA_W - OUT_BITS)'(0), out_reg.mask, out_reg.idx, out_reg.hit};

    // a result only appears at the end of a scan
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside DONE");

    // no match means index and mask read as zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[OUT_FOUND_LO]) |-> (m_tdata[OUT_BITS-1:OUT_IDX_LO] == '0))
        else $error("miss result carries non-zero fields");

    // a write transfer never starts a scan
    a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (s_tuser == KIND_WRITE)) |=> (state_reg == ST_IDLE))
        else $error("write transfer left IDLE");

    // scan counter stays inside the table
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (rd_cnt_reg <= LAST_SLOT))
        else $error("scan counter beyond last slot");

endmodule

FILE: test/route_longest_prefix_match_top_test.sv
module route_longest_prefix_match_top_test;
    import rlpm_pkg::*;

    localparam int DEPTH       = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 16;
    // Quiet window (by accepted input count): no idling on either side
    localparam int CALM_FROM   = 500;
    localparam int CALM_TO     = 800;
    // Receiver hold-off: starts after this many results, lasts this many cycles
    localparam int HOLD_AFTER  = 150;
    localparam int HOLD_CYCLES = 200;
    // A lookup walks 32 slots; settle time at the end
    localparam int DRAIN_WAIT  = 40;

    // One input transfer as the sender sees it
    typedef struct {
        logic              kind;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic              valid;
        logic [ADDR_W-1:0] addr;
        bit                drain;   // wait for every result before offering
    } route_item_t;

    // One lookup result
    typedef struct {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] mask;
    } route_match_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [4:0] entry_index, [36:5] entry_dest, [68:37] entry_mask,
    // [69] entry_valid, [101:70] lookup_address, rest zero
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    // [0] kind
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [0] found, [5:1] match_index, [37:6] match_mask, rest zero
    logic [OUT_TDATA_W-1:0] m_tdata;

    route_longest_prefix_match_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Stimulus waiting to be offered, and lookups waiting for their result
    route_item_t  pending_items[$];
    route_match_t expected_matches[$];
    route_item_t  cur_item;
    bit           hold_for_drain = 1'b0;

    // Private copy of the routing table
    logic [ADDR_W-1:0] route_dest [DEPTH];
    logic [ADDR_W-1:0] route_mask [DEPTH];
    logic              route_live [DEPTH];

    int  in_count  = 0;
    int  out_count = 0;
    int  errors    = 0;
    int  n_writes  = 0;
    int  n_lookups = 0;
    int  n_hits    = 0;
    int  n_default = 0;
    int  cycle_count = 0;
    bit  s_taken   = 1'b0;
    bit  send_now;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    logic [IN_TDATA_W-1:0] tdata_next;

    wire calm = (in_count >= CALM_FROM) && (in_count < CALM_TO);

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            route_live[i] = 1'b0;
    end

    // Longest prefix search over the private table: greatest mask wins,
    // lowest slot on a tie; a mask of zero is a default route and matches all.
    function automatic route_match_t best_route(input logic [ADDR_W-1:0] addr);
        route_match_t best;
        best = '{found: 1'b0, idx: '0, mask: '0};
        for (int i = 0; i < DEPTH; i++)
        begin
            if (route_live[i] && ((addr ^ route_dest[i]) & route_mask[i]) == '0)
            begin
                if (!best.found || route_mask[i] > best.mask)
                begin
                    best.found = 1'b1;
                    best.idx   = i[IDX_W-1:0];
                    best.mask  = route_mask[i];
                end
            end
        end
        return best;
    endfunction

    task automatic add_write(input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] dest,
                             input logic [ADDR_W-1:0] mask, input logic valid);
        route_item_t it;
        it.kind  = KIND_WRITE;
        it.idx   = idx;
        it.dest  = dest;
        it.mask  = mask;
        it.valid = valid;
        it.addr  = $urandom;         // ignored on a write
        it.drain = hold_for_drain;
        hold_for_drain = 1'b0;
        pending_items.push_back(it);
    endtask

    task automatic add_lookup(input logic [ADDR_W-1:0] addr);
        route_item_t it;
        it.kind  = KIND_LOOKUP;
        it.idx   = IDX_W'($urandom); // entry fields ignored on a lookup
        it.dest  = $urandom;
        it.mask  = $urandom;
        it.valid = 1'($urandom);
        it.addr  = addr;
        it.drain = hold_for_drain;
        hold_for_drain = 1'b0;
        pending_items.push_back(it);
    endtask

    task automatic check_field(input string name, input logic [ADDR_W-1:0] exp_val,
                               input logic [ADDR_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, exp_val, act_val);
        end
    endtask

    // Sender: a new transfer is set up at the falling edge once the previous
    // one has been taken. Items flagged for drain wait for an empty scoreboard.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_taken))
        begin
            send_now = pending_items.size() != 0
                       && !(pending_items[0].drain && expected_matches.size() != 0)
                       && (calm || $urandom_range(0, 99) >= IDLE_PCT);
            if (send_now)
            begin
                cur_item = pending_items.pop_front();
                tdata_next = '0;
                tdata_next[IN_IDX_LO   +: IDX_W]  = cur_item.idx;
                tdata_next[IN_DEST_LO  +: ADDR_W] = cur_item.dest;
                tdata_next[IN_MASK_LO  +: ADDR_W] = cur_item.mask;
                tdata_next[IN_VALID_LO]           = cur_item.valid;
                tdata_next[IN_ADDR_LO  +: ADDR_W] = cur_item.addr;
                s_tdata <= tdata_next;
                s_tuser <= cur_item.kind;
            end
            s_tvalid <= send_now;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off so that the
    // output register fills and the block stops taking transfers.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && out_count >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Both sides sampled at the rising edge: an accepted input updates the
    // private table or queues the expected match; an accepted output is
    // checked against the oldest expectation.
    always @(posedge clk)
    begin
        route_match_t want;
        if (rst_n)
        begin
            s_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                in_count++;
                if (cur_item.kind == KIND_WRITE)
                begin
                    n_writes++;
                    route_dest[cur_item.idx] = cur_item.dest;
                    route_mask[cur_item.idx] = cur_item.mask;
                    route_live[cur_item.idx] = cur_item.valid;
                end
                else
                begin
                    n_lookups++;
                    want = best_route(cur_item.addr);
                    if (want.found)
                        n_hits++;
                    if (want.found && want.mask == '0)
                        n_default++;
                    expected_matches.push_back(want);
                end
            end
            if (m_tvalid && m_tready)
            begin
                out_count++;
                if (expected_matches.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_matches.pop_front();
                    check_field("found", ADDR_W'(want.found),
                                ADDR_W'(m_tdata[OUT_FOUND_LO]));
                    check_field("match_index", ADDR_W'(want.idx),
                                ADDR_W'(m_tdata[OUT_IDX_LO +: IDX_W]));
                    check_field("match_mask", want.mask, m_tdata[OUT_MASK_LO +: ADDR_W]);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still outstanding",
                     $time, expected_matches.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [ADDR_W-1:0] prefix_pool [4];
        logic [ADDR_W-1:0] m;
        int                phase_len;
        int                r;

        // Directed: empty table, default route, host route, ties on equal
        // masks, invalidation, a non-contiguous mask and address extremes.
        add_lookup(32'h0000_0000);
        add_lookup(32'hFFFF_FFFF);
        add_write(5'd0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        add_lookup(32'h0000_0000);
        add_write(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_lookup(32'hFFFF_FFFF);
        add_lookup(32'hFFFF_FFFE);
        add_write(5'd5, 32'h0A00_0000, 32'hFF00_0000, 1'b1);
        add_write(5'd3, 32'h0AFF_FFFF, 32'hFF00_0000, 1'b1);
        add_lookup(32'h0A01_0203);
        add_write(5'd3, 32'h0A00_0000, 32'hFF00_0000, 1'b0);
        add_lookup(32'h0A01_0203);
        add_write(5'd7, 32'h0000_0000, 32'hF0F0_F0F0, 1'b1);
        add_lookup(32'h0A0A_0A0A);
        add_write(5'd16, 32'h0A0A_0000, 32'hFFFF_0000, 1'b1);
        add_lookup(32'h0A0A_0A0A);
        add_write(5'd0, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_lookup(32'h5555_5555);
        add_write(5'd31, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_write(5'd10, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        add_lookup(32'h0000_0000);
        add_lookup(32'hAAAA_AAAA);

        // Random phases: routes built around a few related prefixes so that
        // nested matches compete, lookups mostly close to those prefixes.
        while (pending_items.size() < 1450)
        begin
            prefix_pool[0] = $urandom;
            for (int k = 1; k < 4; k++)
                prefix_pool[k] = prefix_pool[0] ^ ($urandom >> $urandom_range(0, 24));
            hold_for_drain = 1'b1;
            phase_len = $urandom_range(100, 160);
            repeat (phase_len)
            begin
                r = $urandom_range(0, 99);
                if (r < 38)
                begin
                    if ($urandom_range(0, 99) < 8)
                        m = $urandom;                       // non-contiguous
                    else if ($urandom_range(0, 99) < 6)
                        m = '0;                             // default route
                    else
                        m = ~(32'hFFFF_FFFF >> $urandom_range(1, 32));
                    add_write(IDX_W'($urandom), (prefix_pool[$urandom_range(0, 3)] & m)
                              | ($urandom & ~m), m, $urandom_range(0, 99) < 85);
                end
                else if (r < 90)
                begin
                    add_lookup(prefix_pool[$urandom_range(0, 3)]
                               ^ ($urandom >> $urandom_range(2, 32)));
                end
                else if (r < 96)
                begin
                    add_lookup($urandom);
                end
                else
                begin
                    add_write(IDX_W'($urandom), $urandom, $urandom, 1'($urandom));
                end
            end
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || s_tvalid || expected_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Run covered %0d writes and %0d lookups (%0d hits, %0d on a default route)",
                 n_writes, n_lookups, n_hits, n_default);
        $display("with random stalls, one long output hold-off and %0d mismatches", errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
src/rlpm_pkg.sv
src/rlpm_ram.sv
src/rlpm_cmp.sv
src/route_longest_prefix_match_top.sv
test/route_longest_prefix_match_top_test.sv
